// ===== sv/gbfs_pkg.sv =====
package gbfs_pkg;

    // Sizing defaults and fixed field widths
    localparam int          MAX_SIDE_DEF = 16;
    localparam int          CFG_W        = 5;
    localparam int          COORD_W      = 4;
    localparam int          DIST_W       = 8;
    localparam logic [4:0]  SIDE_RST     = 5'd16;
    localparam logic [7:0]  DIST_SAT     = 8'hFF;

    // Request codes
    localparam logic [1:0]  REQ_WRITE    = 2'd0;
    localparam logic [1:0]  REQ_RUN      = 2'd1;
    localparam logic [1:0]  REQ_QUERY    = 2'd2;

    // Input beat
    typedef struct packed {
        logic [1:0]         req_type;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               blocked;
    } t_req;

    // Result beat
    typedef struct packed {
        logic               reachable;
        logic [DIST_W-1:0]  distance;
    } t_rsp;

    // Operation broadcast to the row cells
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_START,
        CELL_STEP,
        CELL_PICK
    } t_cell_op;

    // Control bundle shared by all row cells
    typedef struct packed {
        t_cell_op           op;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               flag;   // blocked value on write, start in range on start
        logic [CFG_W-1:0]   side;
        logic [DIST_W-1:0]  wave;
    } t_cell_ctl;

    // Column read-out of one row cell
    typedef struct packed {
        logic               hit;
        logic [DIST_W-1:0]  hops;
    } t_pick;

endpackage

// ===== sv/gbfs_row_cell.sv =====
module gbfs_row_cell #(
    parameter int MAX_SIDE = gbfs_pkg::MAX_SIDE_DEF,
    parameter int ROW      = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gbfs_pkg::t_cell_ctl   i_ctl,
    input  logic [MAX_SIDE-1:0]   i_f_up,
    input  logic [MAX_SIDE-1:0]   i_f_dn,
    output logic [MAX_SIDE-1:0]   o_f,
    output gbfs_pkg::t_pick       o_pick
);
    import gbfs_pkg::*;

    logic [MAX_SIDE-1:0] r_blk, r_vis, r_f;
    logic [MAX_SIDE-1:0] n_blk, n_vis, n_f;
    logic [MAX_SIDE-1:0] w_colsel, w_sel, w_live, w_grow;
    logic [DIST_W-1:0]   r_dist [MAX_SIDE];
    logic                w_row_hit, w_row_live;
    t_pick               r_pick, n_pick;

    // Column decode, live mask and wavefront growth for this row
    always_comb begin
        w_row_hit  = (int'(i_ctl.row) == ROW);
        w_row_live = (ROW < int'(i_ctl.side));
        for (int c = 0; c < MAX_SIDE; c++) begin
            w_colsel[c] = (int'(i_ctl.col) == c);
            w_live[c]   = w_row_live && (c < int'(i_ctl.side));
        end
        w_sel  = w_row_hit ? w_colsel : '0;
        w_grow = (i_f_up | i_f_dn | (r_f << 1) | (r_f >> 1)) & w_live & ~r_vis & ~r_blk;
    end

    // Next state of the row bits and the column read-out
    always_comb begin
        n_blk  = r_blk;
        n_vis  = r_vis;
        n_f    = r_f;
        n_pick = r_pick;
        case (i_ctl.op)
            CELL_WRITE: begin
                n_blk = i_ctl.flag ? (r_blk | w_sel) : (r_blk & ~w_sel);
            end
            CELL_START: begin
                n_vis = i_ctl.flag ? w_sel : '0;
                n_f   = n_vis;
            end
            CELL_STEP: begin
                n_vis = r_vis | w_grow;
                n_f   = w_grow;
            end
            CELL_PICK: begin
                n_pick.hit = |(r_vis & w_colsel);
                n_pick.hops = '0;
                for (int c = 0; c < MAX_SIDE; c++) begin
                    if (w_colsel[c]) n_pick.hops = r_dist[c];
                end
            end
            default: ;
        endcase
    end

    // Blocked, visited and frontier bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk <= '0;
            r_vis <= '0;
            r_f   <= '0;
        end else begin
            r_blk <= n_blk;
            r_vis <= n_vis;
            r_f   <= n_f;
        end
    end

    // Hop counts, gated by the visited bits on read
    always_ff @(posedge i_clk) begin
        r_pick <= n_pick;
        for (int c = 0; c < MAX_SIDE; c++) begin
            if (i_ctl.op == CELL_START && w_sel[c]) begin
                r_dist[c] <= '0;
            end else if (i_ctl.op == CELL_STEP && w_grow[c]) begin
                r_dist[c] <= i_ctl.wave;
            end
        end
    end

    assign o_f    = r_f;
    assign o_pick = r_pick;

endmodule

// ===== sv/grid_bfs_distance_map.sv =====
// Grid flood distance map: a square grid of free and blocked cells with a
// breadth-first flood from a start cell.
// Channels: the input beat (i_in_*) carries a request: write a cell's blocked
// bit, run a flood from a cell, or query a cell. Every accepted beat gives one
// result beat on o_out_*; only queries carry a non-zero result. The user
// writes the side in use on i_cfg_* while idle; the block does not enforce it.
// Results: a write or run result is loaded on the cycle after acceptance; a
// query result is registered after the column pick in the row cells (S_PICK)
// and then the row select (S_READ).
// Occupancy: a write leaves the block idle; a query holds it in S_PICK and S_READ;
// a run holds it in S_START, then in S_STEP until the wavefront dies out, as the
// row-cell chain advances the whole wavefront by one hop per cycle.
// Reset: the side returns to 16, all cells are free and nothing is reached.
// Stall: while the receiver stalls a waiting result, the result holds and no
// new beat is taken; a beat is taken again in the cycle the result drains.
module grid_bfs_distance_map #(
    parameter int MAX_SIDE = gbfs_pkg::MAX_SIDE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gbfs_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  gbfs_pkg::t_req                i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output gbfs_pkg::t_rsp                o_out_data
);
    import gbfs_pkg::*;

    localparam int ROW_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_STEP,
        S_PICK,
        S_READ
    } t_state;

    t_state              r_state;
    logic [CFG_W-1:0]    r_side;
    logic [COORD_W-1:0]  r_row, r_col;
    logic                r_hit;
    logic [DIST_W-1:0]   r_wave;
    logic                r_out_valid;
    t_rsp                r_out;

    logic [CFG_W-1:0]    w_side_use;
    logic                w_in_range, w_slot_free, w_in_accept, w_any;
    t_cell_ctl           w_ctl;
    t_pick               w_row_pick;
    logic [MAX_SIDE-1:0] w_f    [MAX_SIDE];
    t_pick               w_pick [MAX_SIDE];

    // Side in use and range check of the incoming cell
    always_comb begin
        w_side_use = (int'(r_side) > MAX_SIDE) ? CFG_W'(MAX_SIDE) : r_side;
        w_in_range = (CFG_W'(i_in_data.row) < w_side_use) &&
                     (CFG_W'(i_in_data.col) < w_side_use);
    end

    // Input handshake: idle and room in the result register
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_in_accept = i_in_valid && (r_state == S_IDLE) && w_slot_free;
    assign o_in_stall  = !((r_state == S_IDLE) && w_slot_free);
    assign o_cfg_ready = 1'b1;

    // Wavefront still alive anywhere in the chain
    always_comb begin
        w_any = 1'b0;
        for (int r = 0; r < MAX_SIDE; r++) begin
            w_any = w_any | (|w_f[r]);
        end
    end

    assign w_row_pick = w_pick[ROW_W'(r_row)];

    // Broadcast control to the row cells
    always_comb begin
        w_ctl      = '0;
        w_ctl.op   = CELL_HOLD;
        w_ctl.side = w_side_use;
        w_ctl.wave = r_wave;
        w_ctl.row  = r_row;
        w_ctl.col  = r_col;
        w_ctl.flag = r_hit;
        case (r_state)
            S_IDLE: begin
                w_ctl.row  = i_in_data.row;
                w_ctl.col  = i_in_data.col;
                w_ctl.flag = i_in_data.blocked;
                if (w_in_accept && i_in_data.req_type == REQ_WRITE && w_in_range) begin
                    w_ctl.op = CELL_WRITE;
                end
            end
            S_START: w_ctl.op = CELL_START;
            S_STEP:  w_ctl.op = CELL_STEP;
            S_PICK:  w_ctl.op = CELL_PICK;
            default: w_ctl.op = CELL_HOLD;
        endcase
    end

    // Chain of row cells, each passing its frontier to both neighbours
    for (genvar r = 0; r < MAX_SIDE; r++) begin : g_row
        logic [MAX_SIDE-1:0] w_up, w_dn;
        if (r == 0) begin : g_top
            assign w_up = '0;
        end else begin : g_mid_up
            assign w_up = w_f[r-1];
        end
        if (r == MAX_SIDE - 1) begin : g_bot
            assign w_dn = '0;
        end else begin : g_mid_dn
            assign w_dn = w_f[r+1];
        end
        gbfs_row_cell #(
            .MAX_SIDE (MAX_SIDE),
            .ROW      (r)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_f_up  (w_up),
            .i_f_dn  (w_dn),
            .o_f     (w_f[r]),
            .o_pick  (w_pick[r])
        );
    end

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_side      <= SIDE_RST;
            r_row       <= '0;
            r_col       <= '0;
            r_hit       <= 1'b0;
            r_wave      <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_side <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        r_row <= i_in_data.row;
                        r_col <= i_in_data.col;
                        r_hit <= w_in_range;
                        if (i_in_data.req_type == REQ_QUERY) begin
                            r_state <= S_PICK;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_out       <= '0;
                            if (i_in_data.req_type == REQ_RUN) begin
                                r_state <= S_START;
                            end
                        end
                    end
                end
                S_START: begin
                    r_wave  <= DIST_W'(1);
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    if (!w_any) begin
                        r_state <= S_IDLE;
                    end
                    if (r_wave != DIST_SAT) begin
                        r_wave <= r_wave + DIST_W'(1);
                    end
                end
                S_PICK: begin
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_out_valid     <= 1'b1;
                    r_out.reachable <= r_hit && w_row_pick.hit;
                    r_out.distance  <= (r_hit && w_row_pick.hit) ? w_row_pick.hops : '0;
                    r_state         <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== sv/gbfs_checker.sv =====
module gbfs_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic                          o_cfg_ready,
    input  logic [gbfs_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  gbfs_pkg::t_req                i_in_data,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  gbfs_pkg::t_rsp                o_out_data
);
    import gbfs_pkg::*;

    logic w_in_beat, w_query;

    assign w_in_beat = i_in_valid && !o_in_stall;
    assign w_query   = (i_in_data.req_type == REQ_QUERY);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed under stall");

    // An unreached cell reports distance zero
    a_unreached_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.reachable |-> o_out_data.distance == '0)
        else $error("unreached result with non-zero distance");

    // Writes, runs and unused codes answer at once with an empty result
    a_plain_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && !w_query |=> o_out_valid && !o_out_data.reachable &&
                                  o_out_data.distance == '0)
        else $error("non-query beat without an empty result");

    // A query answers only after the pick and read states have passed
    a_query_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && w_query |=> !o_out_valid ##1 !o_out_valid ##1 o_out_valid)
        else $error("query result not on its cycle");

    // A run keeps the input side stalled while the flood starts
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && i_in_data.req_type == REQ_RUN |=> o_in_stall)
        else $error("beat taken during a run");

endmodule

bind grid_bfs_distance_map gbfs_checker u_gbfs_checker (.*);
